[src/sspg_pkg.sv]
// Shared types and constants for the stepper step pulse generator.
package sspg_pkg;

  localparam int unsigned PeriodBitsDefault    = 16;
  localparam int unsigned SpeedFracBitsDefault = 4;

  localparam int unsigned BaseRate     = 500000;
  localparam int unsigned BaseRateBits = 19;
  localparam int unsigned SpeedW       = 24;
  localparam int unsigned StepW        = 32;
  localparam int unsigned PeriodOutW   = 16;
  localparam int unsigned OpW          = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_SPEED = 2'd1,
    OP_STEPS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic tick;
    logic set_speed;
    logic set_steps;
    logic div_step;
    logic commit;
  } sspg_cmd_t;

  typedef struct packed {
    logic div_last;
  } sspg_status_t;

endpackage

[src/sspg_ctrl.sv]
// Controller state machine: handshakes, division sequencing, result valid.
module sspg_ctrl import sspg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [OpW-1:0]     operation_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sspg_cmd_t          cmd_o,
  input  sspg_status_t       status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   done_now;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_SPEED)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    done_now = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            OP_TICK:  cmd_o.tick      = 1'b1;
            OP_SPEED: cmd_o.set_speed = 1'b1;
            OP_STEPS: cmd_o.set_steps = 1'b1;
            default:  ;
          endcase
          // speed beats report only after the period is committed
          done_now = (operation_i != OP_SPEED);
        end
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        done_now     = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_now) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/sspg_datapath.sv]
// Datapath: axis state, period counter, step count and serial period divider.
module sspg_datapath import sspg_pkg::*; #(
  parameter int unsigned PERIOD_BITS     = PeriodBitsDefault,
  parameter int unsigned SPEED_FRAC_BITS = SpeedFracBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sspg_cmd_t              cmd_i,
  output sspg_status_t           status_o,
  input  logic signed [SpeedW-1:0] speed_i,
  input  logic [StepW-1:0]       step_count_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_dir_invert_i,
  output logic                   step_pulse_o,
  output logic                   direction_o,
  output logic                   running_o,
  output logic [StepW-1:0]       steps_left_o,
  output logic [PeriodOutW-1:0]  period_value_o
);

  localparam int unsigned NumW  = BaseRateBits + SPEED_FRAC_BITS;
  localparam int unsigned WideW = (NumW > PERIOD_BITS) ? NumW : PERIOD_BITS;
  localparam int unsigned CntW  = $clog2(NumW);
  localparam logic [NumW-1:0]        DivNum    = NumW'(BaseRate) << SPEED_FRAC_BITS;
  localparam logic [PERIOD_BITS-1:0] PeriodMax = {PERIOD_BITS{1'b1}};

  logic [PERIOD_BITS-1:0] tick_cnt_q, tick_cnt_d;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic [StepW-1:0]       steps_q, steps_d;
  logic                   run_q, run_d;
  logic                   dir_q, dir_d;
  logic                   dir_inv_q;

  logic [SpeedW-1:0]      mag_q, mag_d;
  logic                   zero_q, zero_d;
  logic [SpeedW-1:0]      rem_q, rem_d;
  logic [NumW-1:0]        num_q, num_d;
  logic [NumW-1:0]        quo_q, quo_d;
  logic [CntW-1:0]        div_cnt_q, div_cnt_d;

  logic [SpeedW-1:0]      mag_in;
  logic [SpeedW:0]        rem_sh;
  logic                   quo_bit;
  logic [WideW-1:0]       quo_wide;
  logic [PERIOD_BITS-1:0] cnt_next;

  assign mag_in  = speed_i[SpeedW-1] ? (~speed_i + 1'b1) : speed_i;
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign quo_bit = (rem_sh >= {1'b0, mag_q});
  assign quo_wide = WideW'(quo_q);
  assign status_o.div_last = (div_cnt_q == CntW'(NumW - 1));

  // Reload at zero, otherwise count down.
  assign cnt_next = (tick_cnt_q == '0) ? period_q : tick_cnt_q - 1'b1;

  always_comb begin
    tick_cnt_d = tick_cnt_q;
    period_d   = period_q;
    steps_d    = steps_q;
    run_d      = run_q;
    dir_d      = dir_q;
    mag_d      = mag_q;
    zero_d     = zero_q;
    rem_d      = rem_q;
    num_d      = num_q;
    quo_d      = quo_q;
    div_cnt_d  = div_cnt_q;

    if (cmd_i.tick && run_q) begin
      tick_cnt_d = cnt_next;
      if (cnt_next == '0) begin
        if (steps_q == '0) begin
          run_d = 1'b0;
        end else begin
          steps_d = steps_q - 1'b1;
        end
      end
    end

    if (cmd_i.set_steps) begin
      steps_d = step_count_i;
    end

    if (cmd_i.set_speed) begin
      dir_d     = ~speed_i[SpeedW-1];
      run_d     = (mag_in != '0);
      zero_d    = (mag_in == '0);
      mag_d     = mag_in;
      rem_d     = '0;
      num_d     = DivNum;
      quo_d     = '0;
      div_cnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d     = quo_bit ? SpeedW'(rem_sh - {1'b0, mag_q}) : rem_sh[SpeedW-1:0];
      num_d     = num_q << 1;
      quo_d     = {quo_q[NumW-2:0], quo_bit};
      div_cnt_d = div_cnt_q + 1'b1;
    end

    if (cmd_i.commit) begin
      priority if (zero_q || (quo_wide > WideW'(PeriodMax))) begin
        period_d = PeriodMax;
      end else if (quo_q == '0) begin
        period_d = PERIOD_BITS'(1);
      end else begin
        period_d = PERIOD_BITS'(quo_wide);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= '0;
      period_q   <= PeriodMax;
      steps_q    <= '0;
      run_q      <= 1'b0;
      dir_q      <= 1'b0;
      dir_inv_q  <= 1'b0;
    end else begin
      tick_cnt_q <= tick_cnt_d;
      period_q   <= period_d;
      steps_q    <= steps_d;
      run_q      <= run_d;
      dir_q      <= dir_d;
      if (cfg_we_i) begin
        dir_inv_q <= cfg_dir_invert_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    zero_q    <= zero_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    quo_q     <= quo_d;
    div_cnt_q <= div_cnt_d;
  end

  assign step_pulse_o = run_q && (tick_cnt_q < (period_q >> 1));
  assign direction_o  = dir_q ^ dir_inv_q;
  assign running_o    = run_q;
  assign steps_left_o = steps_q;

  if (PERIOD_BITS >= PeriodOutW) begin : g_period_trunc
    assign period_value_o = period_q[PeriodOutW-1:0];
  end else begin : g_period_ext
    assign period_value_o = PeriodOutW'(period_q);
  end

endmodule

[src/stepper_step_pulse_generator_core.sv]
// Top level of the stepper step and direction pulse generator.
// Step/direction generator for one stepper axis. Every input beat yields one
// result beat that reports the axis state after the beat is applied. Clock
// tick, set-steps and unused operation beats report in the next cycle, and a
// new beat is taken in the same cycle that the previous result is taken, so
// ticks stream at one per cycle while results are taken. A set-speed beat
// computes the period (500000 << SPEED_FRAC_BITS) / |speed| with a restoring
// divider that resolves one quotient bit per cycle: the input stalls through
// the divide and commit states, and the result appears once the period is
// committed. The period saturates at the PERIOD_BITS maximum, floors at 1,
// and a zero speed stops the counter. The step output is high while running
// and the down-counter is below half the period. dir_invert flips the
// direction pin polarity; write it only while the block is idle.
module stepper_step_pulse_generator_core import sspg_pkg::*; #(
  parameter int unsigned PERIOD_BITS     = PeriodBitsDefault,
  parameter int unsigned SPEED_FRAC_BITS = SpeedFracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OpW-1:0]           operation_i,
  input  logic signed [SpeedW-1:0] speed_i,
  input  logic [StepW-1:0]         step_count_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     step_pulse_o,
  output logic                     direction_o,
  output logic                     running_o,
  output logic [StepW-1:0]         steps_left_o,
  output logic [PeriodOutW-1:0]    period_value_o,
  // configuration write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_dir_invert_i
);

  sspg_cmd_t    cmd;
  sspg_status_t status;

  // Configuration is always accepted; it only touches the polarity bit.
  assign cfg_ready_o = 1'b1;

  sspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Result fields read straight from the state registers: a new beat is
  // taken only when the pending result leaves, so the state holds with it.
  sspg_datapath #(
    .PERIOD_BITS     (PERIOD_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .speed_i          (speed_i),
    .step_count_i     (step_count_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_dir_invert_i (cfg_dir_invert_i),
    .step_pulse_o     (step_pulse_o),
    .direction_o      (direction_o),
    .running_o        (running_o),
    .steps_left_o     (steps_left_o),
    .period_value_o   (period_value_o)
  );

  // Hold off input while a speed beat is in the divider.
  a_speed_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OP_SPEED)) |=> !in_ready_o)
    else $error("input accepted during period division");

  // Tick beats report in the next cycle.
  a_tick_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OP_TICK)) |=> out_valid_o)
    else $error("tick beat did not produce a result");

  // A stopped axis never drives a step pulse.
  a_no_pulse_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_o |-> !step_pulse_o)
    else $error("step pulse while stopped");

  // The period never reads zero.
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_value_o != '0)
    else $error("period register is zero");

endmodule
